/* hw/rtl/adt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_pkg
// Shared types, field widths and codes for the address dedup table.
// ----------------------------------------------------------------------------
package adt_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH_DEF = 64;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 48;
    localparam int TYPE_W   = 3;
    localparam int STR_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;

    // opcodes
    localparam logic [OP_W-1:0] OP_REPORT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd5;

    // input item
    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [ADDR_W-1:0]       device_address;
        logic [TYPE_W-1:0]       type_code;
        logic signed [STR_W-1:0] signal_strength;
        logic [SLOT_W-1:0]       slot;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       slot_used;
        logic [ADDR_W-1:0]       entry_address;
        logic [TYPE_W-1:0]       entry_type;
        logic signed [STR_W-1:0] entry_strength;
        logic [FILL_W-1:0]       fill_count;
    } rsp_item_t;

    // query token walking down the cell chain
    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [ADDR_W-1:0]       device_address;
        logic [TYPE_W-1:0]       type_code;
        logic signed [STR_W-1:0] signal_strength;
        logic [SLOT_W-1:0]       slot;
        logic                    done;
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       slot_used;
        logic [ADDR_W-1:0]       entry_address;
        logic [TYPE_W-1:0]       entry_type;
        logic signed [STR_W-1:0] entry_strength;
    } token_t;

    // chain control for each cell: its own valid and the shared advance
    typedef struct packed {
        logic valid;
        logic advance;
    } chain_ctl_t;

endpackage

/* hw/rtl/adt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_cell
// One table entry plus one stage of the token chain: compares, updates,
// inserts or reads its entry as the query token passes through.
// ----------------------------------------------------------------------------
module adt_cell
    import adt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX         = 0,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctl_t       ctl_in,
    input  token_t           tok_in,
    input  logic [CNT_W-1:0] fill,
    output logic             tok_valid,
    output token_t           tok
);

    localparam logic [CNT_W-1:0]  IDX_C    = CNT_W'(IDX);
    localparam logic [SLOT_W-1:0] IDX_S    = SLOT_W'(IDX);
    localparam bit                READABLE = (IDX < (1 << SLOT_W));

    logic [ADDR_W-1:0]       addr_reg;
    logic [TYPE_W-1:0]       type_reg;
    logic signed [STR_W-1:0] strength_reg;
    token_t                  tok_reg;
    token_t                  tok_next;
    logic                    tok_valid_reg;
    logic                    filled;
    logic                    wr_all;
    logic                    wr_str;

    assign filled = (IDX_C < fill);

    // process the passing token against this entry
    always_comb
    begin
        tok_next = tok_in;
        wr_all   = 1'b0;
        wr_str   = 1'b0;
        case (tok_in.opcode)
            OP_REPORT:
            begin
                if (!tok_in.done)
                begin
                    if (filled && (addr_reg == tok_in.device_address))
                    begin
                        tok_next.done      = 1'b1;
                        tok_next.status    = ST_UPDATED;
                        tok_next.slot_used = IDX_S;
                        wr_str             = 1'b1;
                    end
                    else if (IDX_C == fill)
                    begin
                        tok_next.done      = 1'b1;
                        tok_next.status    = ST_INSERTED;
                        tok_next.slot_used = IDX_S;
                        wr_all             = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (!tok_in.done && READABLE && filled && (tok_in.slot == IDX_S))
                begin
                    tok_next.done           = 1'b1;
                    tok_next.status         = ST_READ_OK;
                    tok_next.slot_used      = IDX_S;
                    tok_next.entry_address  = addr_reg;
                    tok_next.entry_type     = type_reg;
                    tok_next.entry_strength = strength_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (ctl_in.valid && ctl_in.advance)
        begin
            if (wr_all)
            begin
                addr_reg <= tok_in.device_address;
                type_reg <= tok_in.type_code;
            end
            if (wr_all || wr_str)
            begin
                strength_reg <= tok_in.signal_strength;
            end
        end
    end

    // token stage payload
    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            tok_reg <= tok_next;
        end
    end

    // token stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else if (ctl_in.advance)
        begin
            tok_valid_reg <= ctl_in.valid;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

/* hw/rtl/address_dedup_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_dedup_table_top
// Table of seen device addresses held in a chain of cells, one entry per
// cell; a query token walks the chain to update, insert or read.
// ----------------------------------------------------------------------------
// result path: a report or read token passes through the register of every cell
//   of the chain and then the output register; the chain holds while a result is
//   stalled; clear gives its result from the output register; opcode 3 gives no result
// order: one item at a time; no new item is taken while a report or read token
//   walks the cell chain until the busy release, or while a stalled result waits
// reset: fill count cleared to zero, entry contents undefined until written
module address_dedup_table_top
    import adt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             busy_reg;
    logic             busy_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_item_t        rsp_reg;
    rsp_item_t        rsp_next;

    logic             accept;
    logic             launch;
    logic             advance;
    logic             tail_move;
    token_t           launch_tok;
    token_t           tail_tok;
    logic             tail_valid;
    logic             tail_ins;

    chain_ctl_t       ctl [TABLE_DEPTH];
    token_t           tok_in [TABLE_DEPTH];
    token_t           tok_out [TABLE_DEPTH];
    logic             tok_valid [TABLE_DEPTH];

    // input handshake
    assign req_stall = busy_reg | (rsp_valid_reg & rsp_stall);
    assign accept    = req_valid & ~req_stall;
    assign launch    = accept & ((req_item.opcode == OP_REPORT) |
                                 (req_item.opcode == OP_READ));

    // chain holds only while the token at the tail cannot leave
    assign tail_tok   = tok_out[TABLE_DEPTH-1];
    assign tail_valid = tok_valid[TABLE_DEPTH-1];
    assign advance    = ~(tail_valid & rsp_valid_reg & rsp_stall);
    assign tail_move  = tail_valid & advance;
    assign tail_ins   = tail_tok.done & (tail_tok.status == ST_INSERTED);

    // token launched into the first cell
    always_comb
    begin
        launch_tok                 = '0;
        launch_tok.opcode          = req_item.opcode;
        launch_tok.device_address  = req_item.device_address;
        launch_tok.type_code       = req_item.type_code;
        launch_tok.signal_strength = req_item.signal_strength;
        launch_tok.slot            = req_item.slot;
    end

    // cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign ctl[i].valid = launch;
            assign tok_in[i]    = launch_tok;
        end
        else
        begin : g_link
            assign ctl[i].valid = tok_valid[i-1];
            assign tok_in[i]    = tok_out[i-1];
        end
        assign ctl[i].advance = advance;

        adt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl[i]),
            .tok_in    (tok_in[i]),
            .fill      (fill_reg),
            .tok_valid (tok_valid[i]),
            .tok       (tok_out[i])
        );
    end

    // control and result assembly
    always_comb
    begin
        fill_next      = fill_reg;
        busy_next      = busy_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;

        if (launch)
        begin
            busy_next = 1'b1;
        end

        if (accept && (req_item.opcode == OP_CLEAR))
        begin
            fill_next           = '0;
            rsp_next            = '0;
            rsp_next.status     = ST_CLEARED;
            rsp_valid_next      = 1'b1;
        end
        else if (tail_move)
        begin
            busy_next               = 1'b0;
            rsp_valid_next          = 1'b1;
            rsp_next.status         = tail_tok.status;
            rsp_next.slot_used      = tail_tok.slot_used;
            rsp_next.entry_address  = tail_tok.entry_address;
            rsp_next.entry_type     = tail_tok.entry_type;
            rsp_next.entry_strength = tail_tok.entry_strength;
            if (!tail_tok.done)
            begin
                rsp_next.slot_used = '0;
                rsp_next.status    = (tail_tok.opcode == OP_REPORT) ? ST_DROPPED
                                                                    : ST_READ_EMPTY;
            end
            if (tail_ins)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        rsp_next.fill_count = FILL_W'(fill_next);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for address_dedup_table_top. A queue of report, read,
// clear and unused-opcode items feeds a clocked driver with random gaps; a
// clocked monitor runs a software copy of the table on every accepted item
// and compares each result, field by field, in order of arrival. The result
// side stalls at random. Stimulus is a short directed opening followed by
// random sequences that refill the table, revisit addresses and overflow it.
// ----------------------------------------------------------------------------
module testbench;
    import adt_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int ITEM_TARGET = 1870;
    localparam int TAIL_CYCLES = 4 * (DEPTH + 1);

    // opcode the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    // pending items and results still to come
    req_item_t cmd_queue[$];
    rsp_item_t table_answers[$];

    // software copy of the table
    logic [ADDR_W-1:0]       seen_addr[DEPTH];
    logic [TYPE_W-1:0]       seen_type[DEPTH];
    logic signed [STR_W-1:0] seen_strength[DEPTH];
    int                      seen_count = 0;

    int mismatch_count = 0;
    int item_count     = 0;
    bit req_taken      = 1'b0;
    int req_gap        = 0;
    int req_calm       = 0;
    int stall_run      = 0;
    int calm_run       = 0;

    address_dedup_table_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
    end

    // hard limit on run time
    initial
    begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // idle length: mostly zero or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    // item with every field random apart from the opcode
    function automatic req_item_t rand_item(input logic [OP_W-1:0] op);
        req_item_t it;
        it.opcode          = op;
        it.device_address  = rand_addr();
        it.type_code       = TYPE_W'($urandom_range(0, 7));
        it.signal_strength = STR_W'($urandom());
        it.slot            = SLOT_W'($urandom());
        return it;
    endfunction

    task automatic add_item(input req_item_t it);
        cmd_queue.push_back(it);
        if (it.opcode != OP_UNUSED)
            item_count++;
    endtask

    task automatic queue_report(input logic [ADDR_W-1:0] addr);
        req_item_t it;
        it = rand_item(OP_REPORT);
        it.device_address = addr;
        add_item(it);
    endtask

    task automatic queue_read(input logic [SLOT_W-1:0] s);
        req_item_t it;
        it = rand_item(OP_READ);
        it.slot = s;
        add_item(it);
    endtask

    // expected result of one item against the table copy
    task automatic table_predict(input req_item_t it, output bit has_result,
                                 output rsp_item_t r);
        bit hit;
        r          = '0;
        has_result = 1'b1;
        hit        = 1'b0;
        case (it.opcode)
            OP_REPORT:
            begin
                // lowest matching slot wins, only strength changes
                for (int i = 0; i < seen_count; i++)
                begin
                    if (!hit && seen_addr[i] == it.device_address)
                    begin
                        seen_strength[i] = it.signal_strength;
                        r.status         = ST_UPDATED;
                        r.slot_used      = SLOT_W'(i);
                        hit              = 1'b1;
                    end
                end
                if (!hit && seen_count < DEPTH)
                begin
                    seen_addr[seen_count]     = it.device_address;
                    seen_type[seen_count]     = it.type_code;
                    seen_strength[seen_count] = it.signal_strength;
                    r.status                  = ST_INSERTED;
                    r.slot_used               = SLOT_W'(seen_count);
                    seen_count++;
                end
                else if (!hit)
                    r.status = ST_DROPPED;
            end
            OP_READ:
            begin
                if (int'(it.slot) < seen_count)
                begin
                    r.status         = ST_READ_OK;
                    r.slot_used      = it.slot;
                    r.entry_address  = seen_addr[it.slot];
                    r.entry_type     = seen_type[it.slot];
                    r.entry_strength = seen_strength[it.slot];
                end
                else
                    r.status = ST_READ_EMPTY;
            end
            OP_CLEAR:
            begin
                seen_count = 0;
                r.status   = ST_CLEARED;
            end
            default:
                has_result = 1'b0;
        endcase
        r.fill_count = FILL_W'(seen_count);
    endtask

    task automatic show_mismatch(input string field, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        $display("%0t mismatch %s expected %0h actual %0h", $time, field, exp_val,
                 act_val);
        mismatch_count++;
    endtask

    // item driver, changes inputs on the falling edge
    always @(negedge clk)
    begin : req_driver
        logic      next_valid;
        req_item_t next_item;
        next_valid = req_valid;
        next_item  = req_item;
        if (rst_n && (!req_valid || req_taken))
        begin
            next_valid = 1'b0;
            if (req_gap > 0)
                req_gap--;
            else if (cmd_queue.size() > 0)
            begin
                next_valid = 1'b1;
                next_item  = cmd_queue.pop_front();
                if (req_calm > 0)
                begin
                    req_calm--;
                    req_gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 99) == 0)
                        req_calm = $urandom_range(30, 120);
                    req_gap = idle_length();
                end
            end
        end
        req_taken = 1'b0;
        req_valid <= next_valid;
        req_item  <= next_item;
    end

    // result-side stall pattern
    always @(negedge clk)
    begin : rsp_throttle
        if (stall_run > 0)
        begin
            stall_run--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (calm_run > 0)
                calm_run--;
            else if ($urandom_range(0, 1999) == 0)
                calm_run = $urandom_range(200, 800);
            else if ($urandom_range(0, 3) == 0)
                stall_run = idle_length();
        end
    end

    // monitor: check results, then predict accepted items
    always @(posedge clk)
    begin : monitor
        bit        has_result;
        rsp_item_t answer;
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (table_answers.size() == 0)
            begin
                $display("%0t unexpected result status %0d fill %0d", $time,
                         rsp_item.status, rsp_item.fill_count);
                mismatch_count++;
            end
            else
            begin
                want = table_answers.pop_front();
                if (rsp_item.status !== want.status)
                    show_mismatch("status", want.status, rsp_item.status);
                if (rsp_item.slot_used !== want.slot_used)
                    show_mismatch("slot_used", want.slot_used, rsp_item.slot_used);
                if (rsp_item.entry_address !== want.entry_address)
                    show_mismatch("entry_address", want.entry_address,
                                  rsp_item.entry_address);
                if (rsp_item.entry_type !== want.entry_type)
                    show_mismatch("entry_type", want.entry_type, rsp_item.entry_type);
                if (rsp_item.entry_strength !== want.entry_strength)
                    show_mismatch("entry_strength", $unsigned(want.entry_strength),
                                  $unsigned(rsp_item.entry_strength));
                if (rsp_item.fill_count !== want.fill_count)
                    show_mismatch("fill_count", want.fill_count, rsp_item.fill_count);
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            req_taken = 1'b1;
            table_predict(req_item, has_result, answer);
            if (has_result)
                table_answers.push_back(answer);
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        req_item_t         it;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] pool[$];
        logic [ADDR_W-1:0] filled[$];
        int                seq_no;
        int                pick;
        int                n;
        int                r;

        // directed opening
        queue_read('0);
        it = rand_item(OP_REPORT);
        it.device_address  = '0;
        it.type_code       = 3'd0;
        it.signal_strength = 8'sh80;
        add_item(it);
        it = rand_item(OP_REPORT);
        it.device_address  = '1;
        it.type_code       = 3'd7;
        it.signal_strength = 8'sh7F;
        add_item(it);
        // same address again: strength only
        it = rand_item(OP_REPORT);
        it.device_address  = '0;
        it.type_code       = 3'd4;
        it.signal_strength = 8'sh00;
        add_item(it);
        // addresses one bit away from stored ones
        it = rand_item(OP_REPORT);
        it.device_address  = 48'h0000_0000_0001;
        it.type_code       = 3'd5;
        it.signal_strength = 8'shFF;
        add_item(it);
        it = rand_item(OP_REPORT);
        it.device_address  = 48'h7FFF_FFFF_FFFF;
        it.type_code       = 3'd6;
        it.signal_strength = 8'sh01;
        add_item(it);
        for (int s = 0; s < 4; s++)
            queue_read(SLOT_W'(s));
        // read at and beyond the fill count
        queue_read(SLOT_W'(4));
        queue_read('1);
        // unused opcode must leave the table alone
        it = rand_item(OP_UNUSED);
        it.device_address = '0;
        add_item(it);
        queue_read('0);
        add_item(rand_item(OP_CLEAR));
        queue_read('0);
        // stale contents must not show after a clear
        it = rand_item(OP_REPORT);
        it.device_address  = '1;
        it.type_code       = 3'd2;
        it.signal_strength = 8'sh2A;
        add_item(it);
        queue_read('0);
        add_item(rand_item(OP_CLEAR));
        add_item(rand_item(OP_CLEAR));

        // random sequences, the first one fills the table
        seq_no = 0;
        while (item_count < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (seq_no == 0 || pick < 15)
            begin
                // fill to the top, then overflow and update on a full table
                add_item(rand_item(OP_CLEAR));
                filled.delete();
                while (filled.size() < DEPTH)
                begin
                    if (filled.size() > 0 && $urandom_range(0, 3) == 0)
                        queue_report(filled[$urandom_range(0, filled.size() - 1)]);
                    else
                    begin
                        a = rand_addr();
                        filled.push_back(a);
                        queue_report(a);
                    end
                end
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    queue_report(rand_addr());
                    queue_report(filled[$urandom_range(0, filled.size() - 1)]);
                end
                queue_read(SLOT_W'(DEPTH - 1));
                queue_read('0);
                for (int k = 0; k < 4; k++)
                    queue_read(SLOT_W'($urandom()));
            end
            else if (pick < 75)
            begin
                // reports over a small address pool with reads mixed in
                pool.delete();
                n = $urandom_range(2, 20);
                for (int k = 0; k < n; k++)
                begin
                    if (pool.size() > 0 && $urandom_range(0, 3) == 0)
                        pool.push_back(pool[$urandom_range(0, pool.size() - 1)]
                                       ^ (48'h1 << $urandom_range(0, ADDR_W - 1)));
                    else
                        pool.push_back(rand_addr());
                end
                n = $urandom_range(10, 60);
                for (int k = 0; k < n; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        queue_report(pool[$urandom_range(0, pool.size() - 1)]);
                    else if (r < 75)
                        queue_report(rand_addr());
                    else if (r < 84)
                        queue_read(SLOT_W'($urandom_range(0, 15)));
                    else if (r < 92)
                        queue_read(SLOT_W'($urandom()));
                    else if (r < 97)
                        add_item(rand_item(OP_UNUSED));
                    else
                        add_item(rand_item(OP_CLEAR));
                end
            end
            else if (pick < 85)
            begin
                // clear, probe, refill a little
                add_item(rand_item(OP_CLEAR));
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    queue_read(SLOT_W'($urandom_range(0, 3)));
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    queue_report(rand_addr());
                queue_read(SLOT_W'($urandom_range(0, 7)));
            end
            else
            begin
                // noise: any opcode, any field
                n = $urandom_range(5, 20);
                for (int k = 0; k < n; k++)
                    add_item(rand_item(OP_W'($urandom_range(0, 3))));
            end
            seq_no++;
        end

        // drain: all items taken, all results in, then a quiet tail
        while (cmd_queue.size() > 0 || req_valid)
            @(posedge clk);
        while (table_answers.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
